>>> src/assert_macros.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define QNR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Assertion failed in the root finder.");

// Next-cycle implication, reset-qualified.
`define QNR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Assertion failed in the root finder.");

`endif

>>> src/qnr_pkg.sv
package qnr_pkg;

	localparam int OP_W = 4;

	localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
	localparam logic [OP_W-1:0] OP_HINIT    = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL      = 4'd3;
	localparam logic [OP_W-1:0] OP_ADD      = 4'd4;
	localparam logic [OP_W-1:0] OP_DIVINIT  = 4'd5;
	localparam logic [OP_W-1:0] OP_DIVSTEP  = 4'd6;
	localparam logic [OP_W-1:0] OP_NEXT     = 4'd7;
	localparam logic [OP_W-1:0] OP_COMMIT   = 4'd8;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_FLAT      = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;

	localparam logic [7:0] REG_ITER_LIMIT = 8'd0;
	localparam logic [7:0] REG_TOLERANCE  = 8'd1;

	localparam logic [7:0]  ITER_LIMIT_RST = 8'd20;
	localparam logic [15:0] TOLERANCE_RST  = 16'd655;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            sel;
		logic [2:0]      idx;
	} cmd_t;

	typedef struct packed {
		logic flat;
		logic conv;
	} sts_t;

endpackage

>>> src/qnr_if.sv
interface qnr_in_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] coef_x4;
	logic signed [W-1:0] coef_x3;
	logic signed [W-1:0] coef_x2;
	logic signed [W-1:0] coef_x1;
	logic signed [W-1:0] coef_x0;

	modport source (output valid, coef_x4, coef_x3, coef_x2, coef_x1, coef_x0, input ready);
	modport sink (input valid, coef_x4, coef_x3, coef_x2, coef_x1, coef_x0, output ready);
endinterface

interface qnr_out_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] root;
	logic [1:0]          exit_status;
	logic [7:0]          steps_used;

	modport source (output valid, root, exit_status, steps_used, input ready);
	modport sink (input valid, root, exit_status, steps_used, output ready);
endinterface

>>> src/quartic_newton_root.sv
// Newton-Raphson root finder for a quartic with signed fixed-point coefficients.
// An item on the coefs channel carries the five coefficients, highest power
// first. The block starts at x = 1.0 and iterates until the derivative is flat,
// the step falls below the tolerance or the iteration limit is reached, then
// presents one item on the result channel with the root, the exit status and
// the number of iterations begun.
// Each iteration runs the two Horner evaluations on one shared multiplier (one
// multiply and one saturating add per coefficient), a flat check, the restoring
// divider and the update. Only one item is in flight; coefs.ready is high while
// the controller idles. The result sits in an output register, so a stalled
// receiver holds only the finished item; the next item may still be accepted
// and iterated, and waits for the register to empty before finishing.
// Reset clears the controller and the output valid flag and loads the
// iteration limit with 20 and the tolerance with 655.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while idle, since the block itself does not enforce this.
module quartic_newton_root #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	qnr_in_if.sink      coefs,
	qnr_out_if.source   result
);
	import qnr_pkg::*;

	logic [7:0]  limit_q;
	logic [15:0] tol_q;
	cmd_t        cmd;
	sts_t        sts;
	logic        out_free, out_load;
	logic [1:0]  status;
	logic [7:0]  steps;
	logic signed [VALUE_WIDTH-1:0] x;

	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] root_q;
	logic [1:0]                    status_q;
	logic [7:0]                    steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ITER_LIMIT_RST;
			tol_q   <= TOLERANCE_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_ITER_LIMIT) limit_q <= cfg_wdata[7:0];
			else if (cfg_index == REG_TOLERANCE) tol_q <= cfg_wdata;
		end
	end

	assign out_free = !out_valid_q || result.ready;

	qnr_ctrl #(.W(VALUE_WIDTH), .F(FRACTION_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (coefs.valid),
		.in_ready (coefs.ready),
		.out_free (out_free),
		.out_load (out_load),
		.limit    (limit_q),
		.sts      (sts),
		.cmd      (cmd),
		.status   (status),
		.steps    (steps)
	);

	qnr_datapath #(.W(VALUE_WIDTH), .F(FRACTION_BITS)) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.coef_x4 (coefs.coef_x4),
		.coef_x3 (coefs.coef_x3),
		.coef_x2 (coefs.coef_x2),
		.coef_x1 (coefs.coef_x1),
		.coef_x0 (coefs.coef_x0),
		.tol     (tol_q),
		.sts     (sts),
		.x       (x)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			root_q   <= x;
			status_q <= status;
			steps_q  <= steps;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.root        = root_q;
	assign result.exit_status = status_q;
	assign result.steps_used  = steps_q;

`include "assert_macros.svh"

	`QNR_ASSERT_IMP(a_status_code, clk, arst_n, result.valid, result.exit_status != 2'd3)
	`QNR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, coefs.valid && coefs.ready, !coefs.ready)
	`QNR_ASSERT_IMP(a_steps_bound, clk, arst_n, out_load, steps <= limit_q)
	`QNR_ASSERT_IMP(a_load_when_free, clk, arst_n, out_load, !out_valid_q || result.ready)

endmodule

>>> src/qnr_datapath.sv
module qnr_datapath #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  qnr_pkg::cmd_t       cmd,
	input  logic signed [W-1:0] coef_x4,
	input  logic signed [W-1:0] coef_x3,
	input  logic signed [W-1:0] coef_x2,
	input  logic signed [W-1:0] coef_x1,
	input  logic signed [W-1:0] coef_x0,
	input  logic [15:0]         tol,
	output qnr_pkg::sts_t       sts,
	output logic signed [W-1:0] x
);
	import qnr_pkg::*;

	localparam int QW = W + F;
	localparam int MW = 2 * W + F + 1;
	localparam int CW = (W > 16) ? W + 1 : 17;
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE =
		(F >= W - 1) ? VMAX : W'(64'd1 << F);
	localparam logic [MW-1:0] HALF_MAG = {1'b1, {(W-1){1'b0}}};

	logic signed [W-1:0] p_q [5];
	logic signed [W-1:0] dp_q [4];
	logic signed [W-1:0] x_q, acc_q, dacc_q, next_q;
	logic [2*W-1:0]      prod_s1;
	logic                pneg_s1;
	logic [QW-1:0]       num_q, quot_q;
	logic [W-1:0]        den_q;
	logic [W:0]          rem_q;
	logic                qneg_q, nzero_q;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? W'(-v) : v;
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) sat_add = s[W] ? VMIN : VMAX;
		else sat_add = s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) sat_sub = s[W] ? VMIN : VMAX;
		else sat_sub = s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
		if (neg) from_mag = (m >= HALF_MAG) ? VMIN : W'(-m[W-1:0]);
		else from_mag = (m > MW'(VMAX)) ? VMAX : m[W-1:0];
	endfunction

	function automatic logic below_tol(input logic signed [W-1:0] v, input logic [15:0] t);
		below_tol = CW'(mag(v)) < CW'(t);
	endfunction

	logic signed [W-1:0] mul_src, add_src, rounded, quot_sat;
	logic [MW-1:0]       rnd_sum;
	logic [W:0]          rem_sh;

	always_comb begin
		mul_src  = cmd.sel ? dacc_q : acc_q;
		add_src  = cmd.sel ? dp_q[cmd.idx[1:0]] : p_q[cmd.idx];
		rnd_sum  = (MW'(prod_s1) + (MW'(1) << (F - 1))) >> F;
		rounded  = from_mag(pneg_s1, rnd_sum);
		rem_sh   = {rem_q[W-1:0], num_q[QW-1]};
		quot_sat = nzero_q ? '0 : from_mag(qneg_q, MW'(quot_q));
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				p_q[0]  <= coef_x4;
				p_q[1]  <= coef_x3;
				p_q[2]  <= coef_x2;
				p_q[3]  <= coef_x1;
				p_q[4]  <= coef_x0;
				dp_q[0] <= sat_add(sat_add(coef_x4, coef_x4), sat_add(coef_x4, coef_x4));
				dp_q[1] <= sat_add(sat_add(coef_x3, coef_x3), coef_x3);
				dp_q[2] <= sat_add(coef_x2, coef_x2);
				dp_q[3] <= coef_x1;
				x_q     <= ONE;
			end
			OP_HINIT: begin
				acc_q  <= p_q[0];
				dacc_q <= dp_q[0];
			end
			OP_MUL: begin
				prod_s1 <= (2*W)'(mag(mul_src)) * (2*W)'(mag(x_q));
				pneg_s1 <= mul_src[W-1] != x_q[W-1];
			end
			OP_ADD: begin
				if (cmd.sel) dacc_q <= sat_add(rounded, add_src);
				else acc_q <= sat_add(rounded, add_src);
			end
			OP_DIVINIT: begin
				num_q   <= QW'(mag(acc_q)) << F;
				den_q   <= mag(dacc_q);
				rem_q   <= '0;
				quot_q  <= '0;
				qneg_q  <= acc_q[W-1] != dacc_q[W-1];
				nzero_q <= acc_q == '0;
			end
			OP_DIVSTEP: begin
				num_q <= num_q << 1;
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q  <= rem_sh - {1'b0, den_q};
					quot_q <= {quot_q[QW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					quot_q <= {quot_q[QW-2:0], 1'b0};
				end
			end
			OP_NEXT: begin
				next_q <= sat_sub(x_q, quot_sat);
			end
			OP_COMMIT: begin
				x_q <= next_q;
			end
			default: begin
			end
		endcase
	end

	assign sts.flat = below_tol(dacc_q, tol);
	assign sts.conv = below_tol(sat_sub(next_q, x_q), tol);
	assign x = x_q;

endmodule

>>> src/qnr_ctrl.sv
module qnr_ctrl #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_free,
	output logic          out_load,
	input  logic [7:0]    limit,
	input  qnr_pkg::sts_t sts,
	output qnr_pkg::cmd_t cmd,
	output logic [1:0]    status,
	output logic [7:0]    steps
);
	import qnr_pkg::*;

	localparam int QW = W + F;
	localparam int DCW = $clog2(QW + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HINIT = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_ADD   = 4'd3;
	localparam logic [3:0] S_FLAT  = 4'd4;
	localparam logic [3:0] S_DIVI  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_NEXT  = 4'd7;
	localparam logic [3:0] S_CONV  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]     state_q;
	logic           sel_q;
	logic [2:0]     k_q;
	logic [7:0]     it_q;
	logic [DCW-1:0] dcnt_q;
	logic [1:0]     status_q;
	logic [7:0]     steps_q;

	assign in_ready = state_q == S_IDLE;
	assign out_load = (state_q == S_DONE) && out_free;
	assign status   = status_q;
	assign steps    = steps_q;

	always_comb begin
		cmd     = '0;
		cmd.op  = OP_NONE;
		cmd.sel = sel_q;
		cmd.idx = k_q;
		case (state_q)
			S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
			S_HINIT: if (it_q < limit) cmd.op = OP_HINIT;
			S_MUL:   cmd.op = OP_MUL;
			S_ADD:   cmd.op = OP_ADD;
			S_DIVI:  cmd.op = OP_DIVINIT;
			S_DIV:   cmd.op = OP_DIVSTEP;
			S_NEXT:  cmd.op = OP_NEXT;
			S_CONV:  cmd.op = OP_COMMIT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_q    <= 1'b0;
			k_q      <= '0;
			it_q     <= '0;
			dcnt_q   <= '0;
			status_q <= ST_LIMIT;
			steps_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						it_q    <= '0;
						state_q <= S_HINIT;
					end
				end
				S_HINIT: begin
					if (it_q < limit) begin
						sel_q   <= 1'b0;
						k_q     <= 3'd1;
						state_q <= S_MUL;
					end else begin
						status_q <= ST_LIMIT;
						steps_q  <= limit;
						state_q  <= S_DONE;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (!sel_q && k_q == 3'd4) begin
						sel_q   <= 1'b1;
						k_q     <= 3'd1;
						state_q <= S_MUL;
					end else if (sel_q && k_q == 3'd3) begin
						state_q <= S_FLAT;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_MUL;
					end
				end
				S_FLAT: begin
					if (sts.flat) begin
						status_q <= ST_FLAT;
						steps_q  <= it_q + 8'd1;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					dcnt_q  <= DCW'(QW - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == '0) state_q <= S_NEXT;
				end
				S_NEXT: state_q <= S_CONV;
				S_CONV: begin
					if (sts.conv) begin
						status_q <= ST_CONVERGED;
						steps_q  <= it_q + 8'd1;
						state_q  <= S_DONE;
					end else begin
						it_q    <= it_q + 8'd1;
						state_q <= S_HINIT;
					end
				end
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> sim/quartic_newton_root_test.sv
`timescale 1ns / 100ps

module quartic_newton_root_test;
	import qnr_pkg::*;

	localparam int W = 32;
	localparam int FB = 16;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	typedef struct {
		logic signed [W-1:0] root;
		logic [1:0]          exit_status;
		logic [7:0]          steps_used;
	} root_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	qnr_in_if #(.W(W)) coefs();
	qnr_out_if #(.W(W)) result();

	quartic_newton_root #(.VALUE_WIDTH(W), .FRACTION_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .coefs(coefs.sink), .result(result.source)
	);

	always #5 clk = ~clk;

	logic [7:0]   model_limit;
	logic [15:0]  model_tol;
	root_result_t pending_roots[$];
	int           mismatches = 0;
	int           items_sent = 0;
	int           results_seen = 0;
	int           status_count[3] = '{0, 0, 0};
	bit           calm = 1'b0;

	initial begin
		coefs.valid = 1'b0;
		coefs.coef_x4 = '0;
		coefs.coef_x3 = '0;
		coefs.coef_x2 = '0;
		coefs.coef_x1 = '0;
		coefs.coef_x0 = '0;
		result.ready = 1'b0;
	end

	function automatic longint sat(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	function automatic longint mag_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Operands are at most 32 bits wide, so a 64-bit product is exact.
	function automatic longint fix_mul(longint a, longint b);
		longint p;
		p = mag_of(a) * mag_of(b);
		p = (p + (64'sd1 << (FB - 1))) >>> FB;
		return sat(((a < 0) != (b < 0)) ? -p : p);
	endfunction

	function automatic longint fix_div(longint n, longint d);
		longint q;
		if (d == 0) begin
			if (n == 0) return 0;
			return n < 0 ? VMIN : VMAX;
		end
		q = (mag_of(n) << FB) / mag_of(d);
		return sat(((n < 0) != (d < 0)) ? -q : q);
	endfunction

	function automatic longint poly_eval(longint c[5], int n, longint x);
		longint acc;
		acc = c[0];
		for (int i = 1; i < n; i++) acc = sat(fix_mul(acc, x) + c[i]);
		return acc;
	endfunction

	function automatic root_result_t newton_solve(logic signed [W-1:0] k[5]);
		longint p[5], dp[5], x, y, dy, nxt;
		root_result_t r;
		for (int i = 0; i < 5; i++) p[i] = k[i];
		dp[0] = sat(sat(p[0] + p[0]) + sat(p[0] + p[0]));
		dp[1] = sat(sat(p[1] + p[1]) + p[1]);
		dp[2] = sat(p[2] + p[2]);
		dp[3] = p[3];
		dp[4] = 0;
		x = 64'sd1 << FB;
		r.exit_status = ST_LIMIT;
		r.steps_used = model_limit;
		for (int i = 0; i < model_limit; i++) begin
			y = poly_eval(p, 5, x);
			dy = poly_eval(dp, 4, x);
			if (mag_of(dy) < model_tol) begin
				r.exit_status = ST_FLAT;
				r.steps_used = 8'(i + 1);
				break;
			end
			nxt = sat(x - fix_div(y, dy));
			if (mag_of(sat(nxt - x)) < model_tol) begin
				x = nxt;
				r.exit_status = ST_CONVERGED;
				r.steps_used = 8'(i + 1);
				break;
			end
			x = nxt;
		end
		r.root = W'(x);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic write_reg(logic [7:0] index, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_ITER_LIMIT) model_limit = value[7:0];
		else if (index == REG_TOLERANCE) model_tol = value;
	endtask

	// The valid flag stays high after an accept; the next call lowers it only
	// when it idles first, and drain lowers it at the end of a test.
	task automatic send_item(logic signed [W-1:0] k[5]);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			coefs.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pending_roots.push_back(newton_solve(k));
		coefs.valid <= 1'b1;
		coefs.coef_x4 <= k[0];
		coefs.coef_x3 <= k[1];
		coefs.coef_x2 <= k[2];
		coefs.coef_x1 <= k[3];
		coefs.coef_x0 <= k[4];
		do @(posedge clk); while (!coefs.ready);
		items_sent++;
	endtask

	task automatic drain();
		coefs.valid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	always begin
		int stall;
		stall = calm ? 0 : $urandom_range(0, 12);
		if (stall > 0) begin
			result.ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		result.ready <= 1'b1;
		do @(posedge clk); while (result.valid !== 1'b1);
		results_seen++;
		if (pending_roots.size() == 0) begin
			report_mismatch("unexpected item", result.root, 0);
		end else begin
			root_result_t e;
			e = pending_roots.pop_front();
			if (result.root !== e.root) report_mismatch("root", result.root, e.root);
			if (result.exit_status !== e.exit_status)
				report_mismatch("exit_status", result.exit_status, e.exit_status);
			if (result.steps_used !== e.steps_used)
				report_mismatch("steps_used", result.steps_used, e.steps_used);
			if (e.exit_status <= ST_LIMIT) status_count[e.exit_status]++;
		end
	end

	function automatic logic signed [W-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 'h3FFFF)) - 'sh20000;
			2: return $signed($urandom_range(0, 'h7FFFF)) - 'sh40000;
			3: return ($urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000);
			4: return 0;
			default: return $signed($urandom_range(0, 'h1FFF)) - 'sh1000;
		endcase
	endfunction

	task automatic send_poly(logic signed [W-1:0] a, b, c, d, e);
		logic signed [W-1:0] k[5];
		k = '{a, b, c, d, e};
		send_item(k);
	endtask

	task automatic test_directed();
		send_poly(0, 0, 32'sh10000, 0, -32'sh20000);
		send_poly(0, 0, 0, 32'sh10000, -32'sh30000);
		send_poly(0, 0, 0, 0, 32'sh10000);
		send_poly(0, 0, 0, 0, 0);
		send_poly(32'sh10000, 0, 0, 0, -32'sh10000);
		send_poly(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_poly(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_poly(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
		send_poly(-1, -1, -1, -1, -1);
		send_poly(1, 1, 1, 1, 1);
		send_poly(0, 32'sh10000, -32'sh30000, 32'sh20000, 0);
		send_poly(0, 0, 32'sh10000, 0, 32'sh10000);
		drain();
		write_reg(REG_ITER_LIMIT, 0);
		send_poly(32'sh10000, 0, 0, 0, -32'sh50000);
		drain();
		write_reg(REG_TOLERANCE, 0);
		write_reg(REG_ITER_LIMIT, 8);
		send_poly(0, 0, 0, 0, 32'sh10000);
		send_poly(0, 0, 32'sh10000, 0, -32'sh20000);
		send_poly(0, 0, 0, 32'sh10000, 0);
		drain();
		write_reg(8'd7, 16'hFFFF);
		write_reg(REG_TOLERANCE, 16'hFFFF);
		write_reg(REG_ITER_LIMIT, 255);
		send_poly(0, 32'sh10000, 0, 32'sh10000, 32'sh30000);
		send_poly(32'sh20000, -32'sh10000, 32'sh7000, 0, -32'sh10000);
		drain();
	endtask

	task automatic test_random(int count, logic [7:0] limit, logic [15:0] tol);
		logic signed [W-1:0] k[5];
		write_reg(REG_ITER_LIMIT, limit);
		write_reg(REG_TOLERANCE, tol);
		for (int n = 0; n < count; n++) begin
			calm = (n % 64) >= 56;
			for (int i = 0; i < 5; i++) k[i] = rand_coef();
			send_item(k);
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		model_limit = ITER_LIMIT_RST;
		model_tol = TOLERANCE_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random(250, ITER_LIMIT_RST, TOLERANCE_RST);
		test_random(150, 8'd5, 16'd1);
		test_random(150, 8'd40, 16'd65535);
		test_random(100, 8'd1, 16'($urandom_range(0, 65535)));
		test_random(80, 8'd255, 16'd0);
		test_random(40, 8'd0, 16'd655);
		$display("Sent %0d coefficient sets, checked %0d results.", items_sent, results_seen);
		$display("Exits: %0d converged, %0d flat, %0d at limit; %0d mismatches.",
			status_count[0], status_count[1], status_count[2], mismatches);
		if (mismatches == 0 && pending_roots.size() == 0) begin
			$display("** quartic_newton_root: PASSED **");
		end else begin
			$display("** quartic_newton_root: FAILED **");
		end
		$finish;
	end

	initial begin
		#250ms;
		$display("Timeout with %0d results outstanding.", pending_roots.size());
		$display("** quartic_newton_root: FAILED **");
		$finish;
	end

endmodule
